// ----- hdl/lqs_pkg.sv -----
// Package for the linear queue with search: sizes, opcodes, status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package lqs_pkg;

  localparam int DEPTH     = 8;
  localparam int PTR_W     = $clog2(DEPTH + 1);  // holds 0..DEPTH
  localparam int IDX_W     = $clog2(DEPTH);      // addresses a slot
  localparam int WORD_W    = 32;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int POS_W     = 4;
  localparam int POS_EXT_W = (PTR_W > POS_W) ? PTR_W : POS_W;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SRCH = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture opcode and value
    logic enq_do;      // write slot / report overflow
    logic deq_rd;      // read slot at head
    logic deq_emit;    // return the word read, advance head
    logic emit_under;  // report empty, rewind on dequeue
    logic scan_init;   // start search at head
    logic scan_step;   // one read/compare step
    logic scan_fin;    // final search result
  } lqs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            out_free;
    logic            scan_busy;
  } lqs_sts_t;

  // slot or offset reduced modulo 16
  function automatic logic [POS_W-1:0] to_pos(input logic [PTR_W-1:0] v);
    logic [POS_EXT_W-1:0] ext;
    ext = POS_EXT_W'(v);
    return ext[POS_W-1:0];
  endfunction

endpackage

// ----- hdl/linear_queue_with_search_unit.sv -----
// Top level of the linear queue with search: controller plus datapath.
// Depends on lqs_pkg, lqs_ctrl and lqs_dp.
//
//   channel  ports                                           direction
//   in       in_valid/in_ready, in_opcode, in_value          input
//   out      out_valid/out_ready, out_status, out_found,     output
//            out_position, out_data_out, out_last
//
// One item at a time. Dequeue goes through an extra state for the registered
// slot memory read. The search scan reads and compares one slot a cycle
// through the single memory read port, unless a stalled output holds it.
// Synchronous active-low reset clears head, fill and all valid flags.
// A stalled output holds the scan when a further match is found.
`timescale 1ns / 1ps

module linear_queue_with_search_unit import lqs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ST_W-1:0]          out_status,
  output logic                     out_found,
  output logic [POS_W-1:0]         out_position,
  output logic signed [WORD_W-1:0] out_data_out,
  output logic                     out_last
);

  lqs_cmd_t cmd;
  lqs_sts_t sts;

  lqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lqs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_position (out_position),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

endmodule

// ----- hdl/lqs_ctrl.sv -----
// Controller FSM for the linear queue with search.
// Depends on lqs_pkg (command and status structs, opcodes).
`timescale 1ns / 1ps

module lqs_ctrl import lqs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lqs_sts_t sts,
  output lqs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_ENQ   = 3'd2;
  localparam logic [2:0] S_DQRD  = 3'd3;
  localparam logic [2:0] S_DQOUT = 3'd4;
  localparam logic [2:0] S_UNDER = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_ENQ:  state_nxt = S_ENQ;
          OP_DEQ:  state_nxt = sts.empty ? S_UNDER : S_DQRD;
          OP_SRCH: begin
            if (sts.empty) begin
              state_nxt = S_UNDER;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          default: state_nxt = S_IDLE;  // unknown opcode: dropped
        endcase
      end
      S_ENQ: begin
        if (sts.out_free) begin
          cmd.enq_do = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DQRD: begin
        cmd.deq_rd = 1'b1;
        state_nxt  = S_DQOUT;
      end
      S_DQOUT: begin
        if (sts.out_free) begin
          cmd.deq_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_UNDER: begin
        if (sts.out_free) begin
          cmd.emit_under = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (!sts.scan_busy) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.scan_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- hdl/lqs_dp.sv -----
// Datapath for the linear queue with search: slot memory, head/fill
// pointers, search scan pipeline, held match and output register.
// Depends on lqs_pkg.
`timescale 1ns / 1ps

module lqs_dp import lqs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [WORD_W-1:0] in_value,
  input  lqs_cmd_t                 cmd,
  output lqs_sts_t                 sts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ST_W-1:0]          out_status,
  output logic                     out_found,
  output logic [POS_W-1:0]         out_position,
  output logic signed [WORD_W-1:0] out_data_out,
  output logic                     out_last
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] key_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  fill_r, fill_nxt;
  logic [PTR_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [PTR_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [POS_W-1:0]  pend_pos_r, pend_pos_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [ST_W-1:0]   out_status_r;
  logic              out_found_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [WORD_W-1:0] out_data_r;
  logic              out_last_r;

  logic              out_free, out_load;
  logic [ST_W-1:0]   o_status;
  logic              o_found;
  logic [POS_W-1:0]  o_pos;
  logic [WORD_W-1:0] o_data;
  logic              o_last;

  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              empty, full, match, scan_block, scan_busy;

  assign out_free   = !out_vld_r || out_ready;
  assign empty      = head_r >= fill_r;
  assign full       = fill_r == PTR_W'(DEPTH);
  assign match      = cmp_vld_r && (rdata_r == key_r);
  // a second match cannot retire the held one until the output drains
  assign scan_block = match && pend_vld_r && !out_free;
  assign scan_busy  = (scan_idx_r < fill_r) || cmp_vld_r;

  assign sts.op        = op_r;
  assign sts.empty     = empty;
  assign sts.out_free  = out_free;
  assign sts.scan_busy = scan_busy;

  always_comb begin
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    scan_idx_nxt = scan_idx_r;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    pend_vld_nxt = pend_vld_r;
    pend_pos_nxt = pend_pos_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head_r[IDX_W-1:0];
    out_load     = 1'b0;
    o_status     = ST_OK;
    o_found      = 1'b0;
    o_pos        = '0;
    o_data       = '0;
    o_last       = 1'b1;

    if (cmd.enq_do) begin
      out_load = 1'b1;
      if (full) begin
        o_status = ST_OVER;
      end else begin
        wr_en    = 1'b1;
        o_pos    = to_pos(fill_r);
        fill_nxt = fill_r + PTR_W'(1);
      end
    end

    if (cmd.deq_rd) rd_en = 1'b1;

    if (cmd.deq_emit) begin
      out_load = 1'b1;
      o_data   = rdata_r;
      head_nxt = head_r + PTR_W'(1);
    end

    if (cmd.emit_under) begin
      out_load = 1'b1;
      o_status = ST_UNDER;
      if (op_r == OP_DEQ) begin
        head_nxt = '0;
        fill_nxt = '0;
      end
    end

    if (cmd.scan_init) begin
      scan_idx_nxt = head_r;
      cmp_vld_nxt  = 1'b0;
      pend_vld_nxt = 1'b0;
    end

    // read stage issues slot scan_idx, compare stage checks the slot most recently read
    if (cmd.scan_step && !scan_block) begin
      if (scan_idx_r < fill_r) begin
        rd_en        = 1'b1;
        rd_addr      = scan_idx_r[IDX_W-1:0];
        cmp_vld_nxt  = 1'b1;
        cmp_idx_nxt  = scan_idx_r;
        scan_idx_nxt = scan_idx_r + PTR_W'(1);
      end else begin
        cmp_vld_nxt = 1'b0;
      end
      if (match) begin
        pend_vld_nxt = 1'b1;
        pend_pos_nxt = to_pos(cmp_idx_r - head_r);
        if (pend_vld_r) begin
          // a later match exists, so the held one is not last
          out_load = 1'b1;
          o_found  = 1'b1;
          o_pos    = pend_pos_r;
          o_last   = 1'b0;
        end
      end
    end

    if (cmd.scan_fin) begin
      out_load = 1'b1;
      o_found  = pend_vld_r;
      o_pos    = pend_vld_r ? pend_pos_r : '0;
    end

    out_vld_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[fill_r[IDX_W-1:0]] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      fill_r     <= '0;
      cmp_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    pend_pos_r <= pend_pos_nxt;
    if (cmd.load) begin
      op_r  <= in_opcode;
      key_r <= in_value;
    end
    if (out_load) begin
      out_status_r <= o_status;
      out_found_r  <= o_found;
      out_pos_r    <= o_pos;
      out_data_r   <= o_data;
      out_last_r   <= o_last;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

  a_head_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= fill_r)
    else $error("head passed fill");

  a_fill_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PTR_W'(DEPTH))
    else $error("fill beyond depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_cmp_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (cmp_idx_r >= head_r && cmp_idx_r < fill_r))
    else $error("compare outside live entries");

endmodule

// ----- test/lqs_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for linear_queue_with_search_unit: keeps a mirror of the queue,
// predicts results for known opcodes and compares result transfers.
// Depends on lqs_pkg.

module lqs_checker import lqs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [ST_W-1:0]          out_status,
  input  logic                     out_found,
  input  logic [POS_W-1:0]         out_position,
  input  logic signed [WORD_W-1:0] out_data_out,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic                     found;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] data;
    logic                     last;
  } queue_result_t;

  logic signed [WORD_W-1:0] mirror_mem [DEPTH];
  logic [PTR_W-1:0]         mirror_head;
  logic [PTR_W-1:0]         mirror_fill;
  queue_result_t            expected_q [$];
  int                       mismatch_cnt = 0;

  assign fail_count = mismatch_cnt;

  function automatic queue_result_t make_result(input logic [ST_W-1:0] status,
                                                input logic found,
                                                input logic [POS_W-1:0] position,
                                                input logic signed [WORD_W-1:0] data,
                                                input logic last);
    queue_result_t r;
    r.status   = status;
    r.found    = found;
    r.position = position;
    r.data     = data;
    r.last     = last;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : scoreboard
    queue_result_t want;
    queue_result_t held;
    logic          have_hit;
    int            i;
    if (!rst_n) begin
      mirror_head = '0;
      mirror_fill = '0;
      expected_q.delete();
      pending <= 0;
    end else begin
      // a result can only belong to an earlier transfer, so check first
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_data_out, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", WORD_W'(out_status), WORD_W'(want.status));
          if (out_found !== want.found)
            report_mismatch("found", WORD_W'(out_found), WORD_W'(want.found));
          if (out_position !== want.position)
            report_mismatch("position", WORD_W'(out_position), WORD_W'(want.position));
          if (out_data_out !== want.data)
            report_mismatch("data_out", out_data_out, want.data);
          if (out_last !== want.last)
            report_mismatch("last", WORD_W'(out_last), WORD_W'(want.last));
        end
      end

      if (in_valid && in_ready) begin
        case (in_opcode)
          OP_ENQ: begin
            // no wraparound: freed front slots are not reused until an underflow rewinds
            if (mirror_fill >= DEPTH) begin
              expected_q.push_back(make_result(ST_OVER, 1'b0, '0, '0, 1'b1));
            end else begin
              mirror_mem[mirror_fill[IDX_W-1:0]] = in_value;
              expected_q.push_back(make_result(ST_OK, 1'b0, POS_W'(mirror_fill), '0, 1'b1));
              mirror_fill = mirror_fill + 1'b1;
            end
          end
          OP_DEQ: begin
            if (mirror_head >= mirror_fill || mirror_head >= DEPTH) begin
              mirror_head = '0;
              mirror_fill = '0;
              expected_q.push_back(make_result(ST_UNDER, 1'b0, '0, '0, 1'b1));
            end else begin
              expected_q.push_back(make_result(ST_OK, 1'b0, '0,
                                               mirror_mem[mirror_head[IDX_W-1:0]], 1'b1));
              mirror_head = mirror_head + 1'b1;
            end
          end
          OP_SRCH: begin
            if (mirror_head >= mirror_fill) begin
              expected_q.push_back(make_result(ST_UNDER, 1'b0, '0, '0, 1'b1));
            end else begin
              // hold back each hit so the final one can carry last
              have_hit = 1'b0;
              for (i = int'(mirror_head); i < mirror_fill && i < DEPTH; i++) begin
                if (mirror_mem[i[IDX_W-1:0]] == in_value) begin
                  if (have_hit) expected_q.push_back(held);
                  held = make_result(ST_OK, 1'b1, POS_W'(i - mirror_head), '0, 1'b0);
                  have_hit = 1'b1;
                end
              end
              if (have_hit) begin
                held.last = 1'b1;
                expected_q.push_back(held);
              end else begin
                expected_q.push_back(make_result(ST_OK, 1'b0, '0, '0, 1'b1));
              end
            end
          end
          default: ;  // unused opcode: dropped by the block
        endcase
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ----- test/linear_queue_with_search_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for linear_queue_with_search_unit: drives directed and random
// queue commands with random idling and gives the verdict.
// Depends on lqs_pkg, lqs_checker and the block itself.

module linear_queue_with_search_unit_tb import lqs_pkg::*;;

  localparam int RANDOM_ITEMS   = 300;
  localparam int HOLD_AT        = 40;    // result count at which the receiver holds off
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;  // not a command, block drops it

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_opcode = OP_ENQ;
  logic signed [WORD_W-1:0] in_value  = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ST_W-1:0]          out_status;
  logic                     out_found;
  logic [POS_W-1:0]         out_position;
  logic signed [WORD_W-1:0] out_data_out;
  logic                     out_last;

  int fail_count;
  int pending;
  int cmds_sent     = 0;
  int results_taken = 0;
  int rx_wait       = 0;
  int idle_cycles   = 0;

  logic signed [WORD_W-1:0] key_pool [4];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  linear_queue_with_search_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_position (out_position),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

  lqs_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_position (out_position),
    .out_data_out (out_data_out),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Result side: random stall after each transfer, bursts with no stall,
  // and one long hold so the block backs up into its input.
  always @(posedge clk) begin : result_sink
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      if (rx_wait == 1) out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      results_taken <= results_taken + 1;
      if (results_taken == HOLD_AT)
        gap = HOLD_CYCLES;
      else if ((results_taken / 48) % 3 == 2)
        gap = 0;
      else
        gap = $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        rx_wait   <= gap;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] val);
    int gap;
    gap = ((cmds_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_NONE) cmds_sent++;
  endtask

  // Mostly keys from a small pool so that searches hit, some extremes and noise.
  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return $urandom;
    if (r == 2) return 32'sh8000_0000;
    if (r == 3) return 32'sh7fff_ffff;
    if (r == 4) return '0;
    if (r == 5) return -32'sd1;
    return key_pool[$urandom_range(0, 3)];
  endfunction

  initial begin : stimulus
    int kind;
    int n;
    int random_start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(OP_SRCH, 32'sd5);              // search on empty queue
    send_cmd(OP_DEQ, '0);                   // dequeue on empty queue
    send_cmd(OP_ENQ, 32'sh8000_0000);
    send_cmd(OP_ENQ, 32'sh7fff_ffff);
    send_cmd(OP_ENQ, '0);
    send_cmd(OP_ENQ, -32'sd1);
    send_cmd(OP_ENQ, 32'sd4);
    send_cmd(OP_ENQ, -32'sd1);
    send_cmd(OP_ENQ, 32'sd5);
    send_cmd(OP_ENQ, -32'sd1);              // last slot used
    send_cmd(OP_ENQ, 32'sd1);               // overflow
    send_cmd(OP_SRCH, -32'sd1);             // several hits
    send_cmd(OP_SRCH, 32'sd123);            // miss
    send_cmd(OP_SRCH, 32'sh8000_0000);      // hit at head
    send_cmd(OP_DEQ, '0);
    send_cmd(OP_DEQ, '0);
    send_cmd(OP_ENQ, 32'sd9);               // overflow although front slots are free
    send_cmd(OP_SRCH, -32'sd1);             // offsets relative to moved head
    send_cmd(OP_NONE, 32'sh5a5a_5a5a);      // unused opcode
    repeat (6) send_cmd(OP_DEQ, '0);
    send_cmd(OP_SRCH, '0);                  // empty with head at the end
    send_cmd(OP_DEQ, '0);                   // underflow rewinds both pointers

    random_start = cmds_sent;
    while (cmds_sent - random_start < RANDOM_ITEMS) begin
      for (int k = 0; k < 4; k++)
        key_pool[k] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 7);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        n = $urandom_range(1, 9);
        repeat (n) send_cmd(OP_ENQ, pick_value());
        repeat ($urandom_range(1, 3)) send_cmd(OP_SRCH, pick_value());
      end else if (kind < 7) begin
        n = $urandom_range(1, 9);
        repeat (n) begin
          send_cmd(OP_DEQ, $urandom);
          if ($urandom_range(0, 2) == 0) send_cmd(OP_SRCH, pick_value());
        end
      end else begin
        // noise: any opcode, any value
        repeat (4) send_cmd(OP_W'($urandom_range(0, 3)), $urandom);
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lqs_pkg.sv
hdl/lqs_ctrl.sv
hdl/lqs_dp.sv
hdl/linear_queue_with_search_unit.sv
test/lqs_checker.sv
test/linear_queue_with_search_unit_tb.sv
